// ===== design/assert_macros.svh =====
// Assertion macros shared by the orbit camera RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OCP_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define OCP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/ocp_pkg.sv =====
// Shared types, constants and helper functions of the orbit camera core.
`default_nettype none
package ocp_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_W         = SINE_FRAC_BITS + 2;
  localparam int ROUND_SHIFT    = 30 - SINE_FRAC_BITS;
  localparam int RANGE_W        = 14;
  localparam int DELTA_W        = RANGE_W + 2;

  localparam int IN_BITS     = 16 + 3 * COORD_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int IN_TX_LSB   = 16;
  localparam int IN_TY_LSB   = 16 + COORD_WIDTH;
  localparam int IN_TZ_LSB   = 16 + 2 * COORD_WIDTH;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROT_SPEED  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZOOM_STEP  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DIST   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIST   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DIST = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILT_MIN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILT_MAX   = 3'd6;

  localparam int MUL_IN_W  = 34;
  localparam int MUL_OUT_W = 2 * MUL_IN_W;

  localparam logic [16:0] FULL_TURN    = 17'd46080;
  localparam logic [16:0] HALF_TURN    = 17'd23040;
  localparam logic [16:0] QUARTER_TURN = 17'd11520;
  localparam logic [16:0] THREE_QUARTER_TURN = 17'd34560;

  // pi/23040 in Q30 is split as 146408 + 19106/23040 per angle unit.
  localparam logic [17:0] RAD_INT  = 18'd146408;
  localparam logic [14:0] RAD_FRAC = 15'd19106;
  localparam int LOOK_OFFSET = 128;

  // Reciprocals ceil(2^(32+l)/d) give exact quotients for 32-bit dividends.
  localparam logic [32:0] RECIP_23040 = 33'(((64'd1 << 47) + 64'd23039) / 64'd23040);
  localparam logic [5:0]  SHIFT_23040 = 6'd47;
  localparam logic [32:0] RECIP_6   = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
  localparam logic [32:0] RECIP_20  = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
  localparam logic [32:0] RECIP_42  = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
  localparam logic [32:0] RECIP_72  = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
  localparam logic [32:0] RECIP_110 = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
  localparam logic [32:0] RECIP_156 = 33'(((64'd1 << 40) + 64'd155) / 64'd156);
  localparam logic [32:0] RECIP_210 = 33'(((64'd1 << 40) + 64'd209) / 64'd210);
  localparam logic [32:0] RECIP_272 = 33'(((64'd1 << 41) + 64'd271) / 64'd272);
  localparam logic [32:0] RECIP_342 = 33'(((64'd1 << 41) + 64'd341) / 64'd342);

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_STEP, DP_UPDATE, DP_REDUCE, DP_MUL_F1, DP_DIV_X,
    DP_MUL_F2, DP_SUM_X, DP_SQUARE, DP_TAKE_X2, DP_MUL_T, DP_DIV_T, DP_ACC_T,
    DP_SINE_OUT, DP_MUL_H, DP_MUL_DY, DP_MUL_DX, DP_MUL_DZ, DP_TAKE_DZ, DP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_STEP, ST_UPDATE, ST_REDUCE, ST_MUL_F1, ST_DIV_X, ST_MUL_F2,
    ST_SUM_X, ST_SQUARE, ST_TAKE_X2, ST_MUL_T, ST_DIV_T, ST_ACC_T, ST_SINE_OUT,
    ST_MUL_H, ST_MUL_DY, ST_MUL_DX, ST_MUL_DZ, ST_TAKE_DZ, ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
    logic [3:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Reciprocal of the Taylor divisor (2k)(2k+1).
  function automatic logic [32:0] div_recip(input logic [3:0] k);
    logic [32:0] r;
    unique case (k)
      4'd1:    r = RECIP_6;
      4'd2:    r = RECIP_20;
      4'd3:    r = RECIP_42;
      4'd4:    r = RECIP_72;
      4'd5:    r = RECIP_110;
      4'd6:    r = RECIP_156;
      4'd7:    r = RECIP_210;
      4'd8:    r = RECIP_272;
      4'd9:    r = RECIP_342;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] div_shift(input logic [3:0] k);
    logic [5:0] s;
    unique case (k)
      4'd1:    s = 6'd35;
      4'd2:    s = 6'd37;
      4'd3:    s = 6'd38;
      4'd4:    s = 6'd39;
      4'd5:    s = 6'd39;
      4'd6:    s = 6'd40;
      4'd7:    s = 6'd40;
      4'd8:    s = 6'd41;
      4'd9:    s = 6'd41;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [COORD_WIDTH:0] v);
    logic [COORD_WIDTH-1:0] r;
    if (v[COORD_WIDTH] != v[COORD_WIDTH-1]) begin
      r = v[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/orbit_camera_position_core.sv =====
// Top level of the orbit camera position core.
// A request is accepted only in the idle state and is carried to its result before the next
// is taken; each of the four sines is a ten-term Taylor series evaluated on the single
// shared 34x34 multiplier.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) loads the register defaults, yaw 0, pitch 30 degrees.
`default_nettype none
module orbit_camera_position_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // zoom_in, zoom_out, key_left, key_right, key_up, key_down, elapsed,
  // target_x, target_y, target_z
  input  wire [ocp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // cam_x, cam_y, cam_z, look_y
  output logic [ocp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [ocp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [ocp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ocp_pkg::dp_cmd_t    cmd;
  ocp_pkg::dp_status_t status;

  ocp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ocp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== design/ocp_ctrl.sv =====
// Sequencer that steps the shared multiplier datapath through one frame.
`default_nettype none
`include "assert_macros.svh"
module ocp_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  ocp_pkg::dp_status_t  status,
  output ocp_pkg::dp_cmd_t     cmd
);

  ocp_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [3:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocp_pkg::ST_IDLE;
      sel_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    k_nxt     = k_r;
    cmd.op    = ocp_pkg::DP_NONE;
    cmd.sel   = sel_r;
    cmd.k     = k_r;
    in_tready = 1'b0;
    unique case (state_r)
      ocp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = ocp_pkg::DP_LOAD;
          state_nxt = ocp_pkg::ST_STEP;
        end
      end
      ocp_pkg::ST_STEP: begin
        cmd.op    = ocp_pkg::DP_STEP;
        state_nxt = ocp_pkg::ST_UPDATE;
      end
      ocp_pkg::ST_UPDATE: begin
        cmd.op    = ocp_pkg::DP_UPDATE;
        sel_nxt   = 2'd0;
        state_nxt = ocp_pkg::ST_REDUCE;
      end
      ocp_pkg::ST_REDUCE: begin
        cmd.op    = ocp_pkg::DP_REDUCE;
        state_nxt = ocp_pkg::ST_MUL_F1;
      end
      ocp_pkg::ST_MUL_F1: begin
        cmd.op    = ocp_pkg::DP_MUL_F1;
        state_nxt = ocp_pkg::ST_DIV_X;
      end
      ocp_pkg::ST_DIV_X: begin
        cmd.op    = ocp_pkg::DP_DIV_X;
        state_nxt = ocp_pkg::ST_MUL_F2;
      end
      ocp_pkg::ST_MUL_F2: begin
        cmd.op    = ocp_pkg::DP_MUL_F2;
        state_nxt = ocp_pkg::ST_SUM_X;
      end
      ocp_pkg::ST_SUM_X: begin
        cmd.op    = ocp_pkg::DP_SUM_X;
        state_nxt = ocp_pkg::ST_SQUARE;
      end
      ocp_pkg::ST_SQUARE: begin
        cmd.op    = ocp_pkg::DP_SQUARE;
        state_nxt = ocp_pkg::ST_TAKE_X2;
      end
      ocp_pkg::ST_TAKE_X2: begin
        cmd.op    = ocp_pkg::DP_TAKE_X2;
        k_nxt     = 4'd1;
        state_nxt = ocp_pkg::ST_MUL_T;
      end
      ocp_pkg::ST_MUL_T: begin
        cmd.op    = ocp_pkg::DP_MUL_T;
        state_nxt = ocp_pkg::ST_DIV_T;
      end
      ocp_pkg::ST_DIV_T: begin
        cmd.op    = ocp_pkg::DP_DIV_T;
        state_nxt = ocp_pkg::ST_ACC_T;
      end
      ocp_pkg::ST_ACC_T: begin
        cmd.op = ocp_pkg::DP_ACC_T;
        if (k_r == 4'd9) begin
          state_nxt = ocp_pkg::ST_SINE_OUT;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ocp_pkg::ST_MUL_T;
        end
      end
      ocp_pkg::ST_SINE_OUT: begin
        cmd.op = ocp_pkg::DP_SINE_OUT;
        if (sel_r == 2'd3) begin
          state_nxt = ocp_pkg::ST_MUL_H;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = ocp_pkg::ST_REDUCE;
        end
      end
      ocp_pkg::ST_MUL_H: begin
        cmd.op    = ocp_pkg::DP_MUL_H;
        state_nxt = ocp_pkg::ST_MUL_DY;
      end
      ocp_pkg::ST_MUL_DY: begin
        cmd.op    = ocp_pkg::DP_MUL_DY;
        state_nxt = ocp_pkg::ST_MUL_DX;
      end
      ocp_pkg::ST_MUL_DX: begin
        cmd.op    = ocp_pkg::DP_MUL_DX;
        state_nxt = ocp_pkg::ST_MUL_DZ;
      end
      ocp_pkg::ST_MUL_DZ: begin
        cmd.op    = ocp_pkg::DP_MUL_DZ;
        state_nxt = ocp_pkg::ST_TAKE_DZ;
      end
      ocp_pkg::ST_TAKE_DZ: begin
        cmd.op    = ocp_pkg::DP_TAKE_DZ;
        state_nxt = ocp_pkg::ST_RESULT;
      end
      ocp_pkg::ST_RESULT: begin
        // Hold the finished request until the output register is free.
        if (status.out_free) begin
          cmd.op    = ocp_pkg::DP_RESULT;
          state_nxt = ocp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ocp_pkg::ST_IDLE;
    endcase
  end

  `OCP_ASSERT_NOW(a_k_in_range, clk, rst_n,
    (state_r == ocp_pkg::ST_MUL_T || state_r == ocp_pkg::ST_DIV_T || state_r == ocp_pkg::ST_ACC_T),
    (k_r >= 4'd1 && k_r <= 4'd9))
  `OCP_ASSERT_NOW(a_all_sines_done, clk, rst_n, (state_r == ocp_pkg::ST_MUL_H), (sel_r == 2'd3))

endmodule
`default_nettype wire

// ===== design/ocp_datapath.sv =====
// Datapath: configuration, camera state, shared multiplier and result register.
`default_nettype none
`include "assert_macros.svh"
module ocp_datapath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  ocp_pkg::dp_cmd_t                   cmd,
  output ocp_pkg::dp_status_t                status,
  input  wire [ocp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [ocp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [ocp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [ocp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW  = ocp_pkg::COORD_WIDTH;
  localparam int CW1 = CW + 1;
  localparam int MIW = ocp_pkg::MUL_IN_W;
  localparam int MOW = ocp_pkg::MUL_OUT_W;
  localparam int SW  = ocp_pkg::SINE_W;
  localparam int DW  = ocp_pkg::DELTA_W;
  localparam int FB  = ocp_pkg::SINE_FRAC_BITS;
  localparam int RS  = ocp_pkg::ROUND_SHIFT;

  // Configuration and camera state.
  logic [8:0]  rot_speed_r;
  logic [11:0] zoom_step_r;
  logic [13:0] min_dist_r, max_dist_r, start_dist_r, tilt_min_r, tilt_max_r;
  logic [15:0] yaw_r, yaw_nxt;
  logic [13:0] pitch_r, pitch_nxt, range_r, range_nxt;

  // Latched request.
  logic [5:0]            keys_r;
  logic [9:0]            elapsed_r;
  logic signed [CW-1:0]  tx_r, ty_r, tz_r;

  // Sine evaluation.
  logic signed [MOW-1:0] prod_r, mul_p, prod_sh;
  logic signed [MIW-1:0] mul_a, mul_b;
  logic [MOW-1:0]        prod_u, t_shift;
  logic [13:0] f_r, f_nxt, xlo_r;
  logic        neg_r, neg_nxt;
  logic [30:0] x_r;
  logic [31:0] x2_r, t_r;
  logic signed [33:0] s_r;
  logic signed [SW-1:0] sine_r [4];
  logic signed [SW-1:0] sine_val;
  logic [30:0] s_clamp;
  logic [31:0] s_rnd;
  logic [SW-2:0] mag;
  logic [16:0] angle, red;

  logic signed [DW-1:0] h_r, dx_r, dy_r, dz_r;

  logic out_valid_r;
  logic [CW-1:0] cam_x_r, cam_y_r, cam_z_r, look_y_r;
  logic signed [CW:0] sum_x, sum_y, sum_z, sum_l;

  // Frame update terms.
  logic [15:0] step;
  logic signed [15:0] rng;
  logic signed [18:0] yw, pt, step_s;

  assign cfg_ready       = 1'b1;
  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = ocp_pkg::OUT_TDATA_W'({look_y_r, cam_z_r, cam_y_r, cam_x_r});

  // Camera state update from the step product.
  always_comb begin
    step   = prod_r[18:3];
    step_s = $signed({3'b0, step});
    rng    = $signed({2'b0, range_r});
    if (keys_r[0]) begin
      rng = rng - $signed({4'b0, zoom_step_r});
      if (rng < $signed({2'b0, min_dist_r})) rng = $signed({2'b0, min_dist_r});
    end
    if (keys_r[1]) begin
      rng = rng + $signed({4'b0, zoom_step_r});
      if (rng > $signed({2'b0, max_dist_r})) rng = $signed({2'b0, max_dist_r});
    end
    range_nxt = rng[13:0];

    yw = $signed({3'b0, yaw_r});
    if (keys_r[2]) yw = yw + step_s;
    if (keys_r[3]) yw = yw - step_s;
    if (yw > $signed({2'b0, ocp_pkg::FULL_TURN})) yw = yw - $signed({2'b0, ocp_pkg::FULL_TURN});
    if (yw < 19'sd0) yw = yw + $signed({2'b0, ocp_pkg::FULL_TURN});
    yaw_nxt = yw[15:0];

    pt = $signed({5'b0, pitch_r});
    if (keys_r[4]) begin
      pt = pt - step_s;
      if (pt < $signed({5'b0, tilt_min_r})) pt = $signed({5'b0, tilt_min_r});
    end
    if (keys_r[5]) begin
      pt = pt + step_s;
      if (pt > $signed({5'b0, tilt_max_r})) pt = $signed({5'b0, tilt_max_r});
    end
    pitch_nxt = pt[13:0];
  end

  // Angle reduction to a quadrant offset; cosine is sine a quarter turn on.
  always_comb begin
    unique case (cmd.sel)
      2'd0:    angle = {3'b0, pitch_r};
      2'd1:    angle = {3'b0, pitch_r} + ocp_pkg::QUARTER_TURN;
      2'd2:    angle = {1'b0, yaw_r};
      default: angle = {1'b0, yaw_r} + ocp_pkg::QUARTER_TURN;
    endcase
    red = (angle >= ocp_pkg::FULL_TURN) ? angle - ocp_pkg::FULL_TURN : angle;
    neg_nxt = (red >= ocp_pkg::HALF_TURN);
    priority if (red < ocp_pkg::QUARTER_TURN) begin
      f_nxt = red[13:0];
    end else if (red < ocp_pkg::HALF_TURN) begin
      f_nxt = 14'(ocp_pkg::HALF_TURN - red);
    end else if (red < ocp_pkg::THREE_QUARTER_TURN) begin
      f_nxt = 14'(red - ocp_pkg::HALF_TURN);
    end else begin
      f_nxt = 14'(ocp_pkg::FULL_TURN - red);
    end
  end

  // Final rounding of the series sum to the sine format.
  always_comb begin
    priority if (s_r < 34'sd0) begin
      s_clamp = '0;
    end else if (s_r > 34'sd1073741824) begin
      s_clamp = 31'd1073741824;
    end else begin
      s_clamp = s_r[30:0];
    end
    s_rnd    = {1'b0, s_clamp} + 32'(1 << (RS - 1));
    mag      = s_rnd[RS +: SW-1];
    sine_val = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      ocp_pkg::DP_STEP: begin
        mul_a = MIW'(rot_speed_r);
        mul_b = MIW'(elapsed_r);
      end
      ocp_pkg::DP_MUL_F1: begin
        mul_a = MIW'(f_r);
        mul_b = MIW'(ocp_pkg::RAD_FRAC);
      end
      ocp_pkg::DP_DIV_X: begin
        mul_a = MIW'(prod_u[31:0]);
        mul_b = MIW'(ocp_pkg::RECIP_23040);
      end
      ocp_pkg::DP_MUL_F2: begin
        mul_a = MIW'(f_r);
        mul_b = MIW'(ocp_pkg::RAD_INT);
      end
      ocp_pkg::DP_SQUARE: begin
        mul_a = MIW'(x_r);
        mul_b = MIW'(x_r);
      end
      ocp_pkg::DP_MUL_T: begin
        mul_a = MIW'(t_r);
        mul_b = MIW'(x2_r);
      end
      ocp_pkg::DP_DIV_T: begin
        mul_a = MIW'(prod_u[61:30]);
        mul_b = MIW'(ocp_pkg::div_recip(cmd.k));
      end
      ocp_pkg::DP_MUL_H: begin
        mul_a = MIW'(range_r);
        mul_b = MIW'(sine_r[1]);
      end
      ocp_pkg::DP_MUL_DY: begin
        mul_a = MIW'(range_r);
        mul_b = MIW'(sine_r[0]);
      end
      ocp_pkg::DP_MUL_DX: begin
        mul_a = MIW'(h_r);
        mul_b = MIW'(sine_r[2]);
      end
      ocp_pkg::DP_MUL_DZ: begin
        mul_a = MIW'(h_r);
        mul_b = MIW'(sine_r[3]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_u  = prod_r;
  assign prod_sh = prod_r >>> FB;
  assign t_shift = prod_u >> ocp_pkg::div_shift(cmd.k);

  always_comb begin
    sum_x = $signed({tx_r[CW-1], tx_r}) + CW1'(dx_r);
    sum_y = $signed({ty_r[CW-1], ty_r}) + CW1'(dy_r);
    sum_z = $signed({tz_r[CW-1], tz_r}) + CW1'(dz_r);
    sum_l = $signed({ty_r[CW-1], ty_r}) + $signed(CW1'(ocp_pkg::LOOK_OFFSET));
  end

  // Control state: configuration, camera state, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_speed_r  <= 9'd100;
      zoom_step_r  <= 12'd384;
      min_dist_r   <= 14'd768;
      max_dist_r   <= 14'd7680;
      start_dist_r <= 14'd2560;
      tilt_min_r   <= 14'd640;
      tilt_max_r   <= 14'd10240;
      yaw_r        <= 16'd0;
      pitch_r      <= 14'd3840;
      range_r      <= 14'd2560;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ocp_pkg::CFG_ROT_SPEED:  rot_speed_r <= cfg_data[8:0];
          ocp_pkg::CFG_ZOOM_STEP:  zoom_step_r <= cfg_data[11:0];
          ocp_pkg::CFG_MIN_DIST:   min_dist_r  <= cfg_data;
          ocp_pkg::CFG_MAX_DIST:   max_dist_r  <= cfg_data;
          ocp_pkg::CFG_START_DIST: begin
            start_dist_r <= cfg_data;
            range_r      <= cfg_data;
          end
          ocp_pkg::CFG_TILT_MIN:   tilt_min_r  <= cfg_data;
          ocp_pkg::CFG_TILT_MAX:   tilt_max_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == ocp_pkg::DP_UPDATE) begin
        yaw_r   <= yaw_nxt;
        pitch_r <= pitch_nxt;
        range_r <= range_nxt;
      end
      if (cmd.op == ocp_pkg::DP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (cmd.op)
      ocp_pkg::DP_LOAD: begin
        keys_r    <= in_tdata[5:0];
        elapsed_r <= in_tdata[15:6];
        tx_r      <= in_tdata[ocp_pkg::IN_TX_LSB +: CW];
        ty_r      <= in_tdata[ocp_pkg::IN_TY_LSB +: CW];
        tz_r      <= in_tdata[ocp_pkg::IN_TZ_LSB +: CW];
      end
      ocp_pkg::DP_REDUCE: begin
        f_r   <= f_nxt;
        neg_r <= neg_nxt;
      end
      ocp_pkg::DP_MUL_F2:   xlo_r <= prod_u[60:47];
      ocp_pkg::DP_SUM_X:    x_r   <= prod_u[30:0] + 31'(xlo_r);
      ocp_pkg::DP_SQUARE: begin
        t_r <= 32'(x_r);
        s_r <= 34'(x_r);
      end
      ocp_pkg::DP_TAKE_X2:  x2_r  <= prod_u[61:30];
      ocp_pkg::DP_ACC_T: begin
        t_r <= t_shift[31:0];
        // Odd terms of the series subtract, even terms add.
        s_r <= cmd.k[0] ? s_r - $signed(34'(t_shift[31:0]))
                        : s_r + $signed(34'(t_shift[31:0]));
      end
      ocp_pkg::DP_SINE_OUT: sine_r[cmd.sel] <= sine_val;
      ocp_pkg::DP_MUL_DY:   h_r  <= prod_sh[DW-1:0];
      ocp_pkg::DP_MUL_DX:   dy_r <= prod_sh[DW-1:0];
      ocp_pkg::DP_MUL_DZ:   dx_r <= prod_sh[DW-1:0];
      ocp_pkg::DP_TAKE_DZ:  dz_r <= prod_sh[DW-1:0];
      ocp_pkg::DP_RESULT: begin
        cam_x_r  <= ocp_pkg::sat_coord(sum_x);
        cam_y_r  <= ocp_pkg::sat_coord(sum_y);
        cam_z_r  <= ocp_pkg::sat_coord(sum_z);
        look_y_r <= ocp_pkg::sat_coord(sum_l);
      end
      default: ;
    endcase
  end

  `OCP_ASSERT_NEXT(a_result_valid, clk, rst_n, (cmd.op == ocp_pkg::DP_RESULT), out_valid_r)
  `OCP_ASSERT_NOW(a_offset_quarter, clk, rst_n, (cmd.op == ocp_pkg::DP_SINE_OUT),
    ({3'b0, f_r} <= ocp_pkg::QUARTER_TURN))

endmodule
`default_nettype wire
